### hw/rtl/maximum_clique_search_core_macros.svh
// ----------------------------------------------------------------------------
// maximum clique search core assertion macros
// Shared concurrent assertion forms, empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef MAXIMUM_CLIQUE_SEARCH_CORE_MACROS_SVH
`define MAXIMUM_CLIQUE_SEARCH_CORE_MACROS_SVH
`ifndef SYNTHESIS
// condition holds at every clock edge out of reset
`define MCS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);
// consequent holds in the same cycle as the antecedent
`define MCS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// consequent holds in the cycle after the antecedent
`define MCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MCS_ASSERT_ALWAYS(lbl, cond, msg)
`define MCS_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define MCS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/mcs_pkg.sv
// ----------------------------------------------------------------------------
// mcs_pkg
// Request codes, field widths and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package mcs_pkg;

    // field widths
    localparam int REQ_W    = 2;
    localparam int VERTEX_W = 6;
    localparam int NUM_W    = 7;
    localparam int MASK_W   = 64;
    localparam int SIZE_W   = 7;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 72;

    // request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_ADD_EDGE = 2'd0,
        REQ_SEARCH   = 2'd1,
        REQ_CLEAR    = 2'd2
    } t_req;

    // controller to datapath commands
    typedef struct packed {
        logic in_load;
        logic graph_clr;
        logic edge_rd_a;
        logic edge_wr_a;
        logic edge_wr_b;
        logic srch_init;
        logic srch_count;
        logic srch_eval;
        logic srch_adj;
        logic srch_pop;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic edge_ok;
        logic no_vertices;
        logic prune;
        logic last_entry;
        logic push_ok;
        logic out_busy;
    } t_stat;

endpackage

### hw/rtl/maximum_clique_search_core.sv
// ----------------------------------------------------------------------------
// maximum_clique_search_core
// Maximum clique search over an adjacency bit matrix, branch and bound.
// ----------------------------------------------------------------------------
// Usage
//   Requests enter on s_axis (tuser the kind, tdata the edge endpoints);
//   each search gives one result on m_axis (tdata mask and size). The
//   vertex count goes on the always ready cfg channel while the core idles.
// Sequence (one request is in work at a time)
//   Clear or unused code: done on acceptance. Add edge: a read-modify-write
//   of one adjacency row per direction, the writes skipped for a self loop.
//   Search: start, root count, last bound check, result load (start and
//   result load with no vertices), plus a bound check and an adjacency read
//   per child tried and a count, last bound check, stack read and parent
//   recount per child pushed; its length follows the search tree.
// Reset and stall
//   Reset empties the graph, sets the vertex count to 64 and drops a pending
//   result. A result held by a low m_axis_tready blocks only the next
//   search, at its end; other requests are still taken.
// ----------------------------------------------------------------------------
module maximum_clique_search_core #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [mcs_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // vertex_a, vertex_b, zero pad
    input  logic [mcs_pkg::REQ_W-1:0]           s_axis_tuser,  // req_type
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mcs_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // clique_mask, clique_size, zero pad
    // configuration
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mcs_pkg::NUM_W-1:0]           i_cfg_data
);

    localparam int VW = mcs_pkg::VERTEX_W;
    localparam int PW = mcs_pkg::OUT_DATA_W - mcs_pkg::MASK_W - mcs_pkg::SIZE_W;

    mcs_pkg::t_cmd  cmd;
    mcs_pkg::t_stat stat;
    logic [mcs_pkg::MASK_W-1:0] clique_mask;
    logic [mcs_pkg::SIZE_W-1:0] clique_size;

    assign o_cfg_ready = 1'b1;

    // sequencer
    mcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_req_type (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // storage and arithmetic
    mcs_dpath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_vertex_a    (s_axis_tdata[VW-1:0]),
        .i_vertex_b    (s_axis_tdata[2*VW-1:VW]),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_clique_mask (clique_mask),
        .o_clique_size (clique_size)
    );

    // result packing
    assign m_axis_tdata = {{PW{1'b0}}, clique_size, clique_mask};

endmodule

### hw/rtl/mcs_ctrl.sv
// ----------------------------------------------------------------------------
// mcs_ctrl
// Sequencer for edge updates, graph clear and the branch-and-bound walk.
// ----------------------------------------------------------------------------
`include "maximum_clique_search_core_macros.svh"

module mcs_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [mcs_pkg::REQ_W-1:0]  i_req_type,
    output logic                       o_in_ready,
    input  mcs_pkg::t_stat             i_stat,
    output mcs_pkg::t_cmd              o_cmd
);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_E_RDA  = 10'b00_0000_0010,
        ST_E_WRA  = 10'b00_0000_0100,
        ST_E_WRB  = 10'b00_0000_1000,
        ST_S_INIT = 10'b00_0001_0000,
        ST_S_CNT  = 10'b00_0010_0000,
        ST_S_EVAL = 10'b00_0100_0000,
        ST_S_ADJ  = 10'b00_1000_0000,
        ST_S_POP  = 10'b01_0000_0000,
        ST_DONE   = 10'b10_0000_0000
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic          accept;
    mcs_pkg::t_req req;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign req        = mcs_pkg::t_req'(i_req_type);

    // next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.in_load = 1'b1;
                    case (req)
                        mcs_pkg::REQ_ADD_EDGE: n_state = ST_E_RDA;
                        mcs_pkg::REQ_SEARCH:   n_state = ST_S_INIT;
                        mcs_pkg::REQ_CLEAR:    o_cmd.graph_clr = 1'b1;
                        default:               n_state = ST_IDLE;
                    endcase
                end
            end
            ST_E_RDA: begin
                o_cmd.edge_rd_a = 1'b1;
                n_state = i_stat.edge_ok ? ST_E_WRA : ST_IDLE;
            end
            ST_E_WRA: begin
                o_cmd.edge_wr_a = 1'b1;
                n_state = ST_E_WRB;
            end
            ST_E_WRB: begin
                o_cmd.edge_wr_b = 1'b1;
                n_state = ST_IDLE;
            end
            ST_S_INIT: begin
                o_cmd.srch_init = 1'b1;
                n_state = i_stat.no_vertices ? ST_DONE : ST_S_CNT;
            end
            ST_S_CNT: begin
                o_cmd.srch_count = 1'b1;
                n_state = ST_S_EVAL;
            end
            ST_S_EVAL: begin
                o_cmd.srch_eval = 1'b1;
                if (!i_stat.prune) begin
                    n_state = ST_S_ADJ;
                end else if (i_stat.last_entry) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_S_POP;
                end
            end
            ST_S_ADJ: begin
                o_cmd.srch_adj = 1'b1;
                n_state = i_stat.push_ok ? ST_S_CNT : ST_S_EVAL;
            end
            ST_S_POP: begin
                o_cmd.srch_pop = 1'b1;
                n_state = ST_S_CNT;
            end
            ST_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `MCS_ASSERT_IMPLIES(a_out_slot_free, o_cmd.out_load, !i_stat.out_busy, "result loaded over a held one")
    `MCS_ASSERT_ALWAYS(a_one_step, $onehot0({o_cmd.edge_rd_a, o_cmd.edge_wr_a, o_cmd.edge_wr_b, o_cmd.srch_init, o_cmd.srch_count, o_cmd.srch_eval, o_cmd.srch_adj, o_cmd.srch_pop}), "two datapath steps at once")

endmodule

### hw/rtl/mcs_dpath.sv
// ----------------------------------------------------------------------------
// mcs_dpath
// Adjacency memory, clique/candidate stack memory, top-of-stack registers,
// counters, best clique and result register.
// ----------------------------------------------------------------------------
`include "maximum_clique_search_core_macros.svh"

module mcs_dpath #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mcs_pkg::t_cmd                 i_cmd,
    output mcs_pkg::t_stat                o_stat,
    input  logic [mcs_pkg::VERTEX_W-1:0]  i_vertex_a,
    input  logic [mcs_pkg::VERTEX_W-1:0]  i_vertex_b,
    input  logic                          i_cfg_valid,
    input  logic [mcs_pkg::NUM_W-1:0]     i_cfg_data,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [mcs_pkg::MASK_W-1:0]    o_clique_mask,
    output logic [mcs_pkg::SIZE_W-1:0]    o_clique_size
);

    localparam int W  = MAX_VERTICES;
    localparam int AW = (W > 1) ? $clog2(W) : 1;
    localparam int CW = $clog2(W + 1);
    localparam int SW = CW + 1;
    localparam int NW = mcs_pkg::NUM_W;
    localparam int VW = mcs_pkg::VERTEX_W;
    localparam int MW = mcs_pkg::MASK_W;
    localparam int ZW = mcs_pkg::SIZE_W;

    // popcount over one mask
    function automatic logic [CW-1:0] f_pop(input logic [W-1:0] x);
        logic [CW-1:0] c;
        c = '0;
        for (int i = 0; i < W; i++) begin
            c = c + CW'(x[i]);
        end
        return c;
    endfunction

    // index of the lowest set bit
    function automatic logic [AW-1:0] f_low(input logic [W-1:0] x);
        logic [AW-1:0] idx;
        idx = '0;
        for (int i = W - 1; i >= 0; i--) begin
            if (x[i]) begin
                idx = AW'(i);
            end
        end
        return idx;
    endfunction

    // memories
    logic [W-1:0]   m_adj [W];
    logic [2*W-1:0] m_stk [W];

    // registers
    logic [NW-1:0]  r_num;
    logic [VW-1:0]  r_va;
    logic [VW-1:0]  r_vb;
    logic [W-1:0]   r_row_vld;
    logic [W-1:0]   r_adj_q;
    logic           r_adj_qv;
    logic [2*W-1:0] r_stk_q;
    logic [W-1:0]   r_clq;
    logic [W-1:0]   r_cand;
    logic [CW-1:0]  r_cs;
    logic [CW-1:0]  r_cc;
    logic [CW-1:0]  r_depth;
    logic [W-1:0]   r_bit;
    logic [W-1:0]   r_best_mask;
    logic [CW-1:0]  r_best_size;
    logic           r_out_vld;
    logic [W-1:0]   r_out_mask;
    logic [CW-1:0]  r_out_size;

    // combinational
    logic [AW-1:0]  va_idx;
    logic [AW-1:0]  vb_idx;
    logic [AW-1:0]  low_idx;
    logic [AW-1:0]  adj_rd_addr;
    logic [W-1:0]   row;
    logic [W-1:0]   child;
    logic [W-1:0]   all_mask;
    logic [CW-1:0]  depth_m1;
    logic [CW-1:0]  depth_m2;
    logic           cs_gt;
    logic [CW-1:0]  best_eff;
    logic           prune;
    logic           leaf_better;
    logic           push_room;

    assign va_idx   = r_va[AW-1:0];
    assign vb_idx   = r_vb[AW-1:0];
    assign low_idx  = f_low(r_cand);
    assign row      = r_adj_qv ? r_adj_q : '0;
    assign child    = r_cand & row;
    assign depth_m1 = r_depth - CW'(1);
    assign depth_m2 = r_depth - CW'(2);

    // vertices below the configured count
    always_comb begin
        for (int i = 0; i < W; i++) begin
            all_mask[i] = (NW'(i) < r_num);
        end
    end

    // bound test against the best size including this node
    assign cs_gt       = r_cs > r_best_size;
    assign best_eff    = cs_gt ? r_cs : r_best_size;
    assign prune       = (r_cand == '0) || ((SW'(r_cs) + SW'(r_cc)) <= SW'(best_eff));
    assign leaf_better = (SW'(r_cs) + SW'(1)) > SW'(r_best_size);
    assign push_room   = r_depth < CW'(W);

    // status to controller
    assign o_stat.edge_ok     = (r_va != r_vb) && ({1'b0, r_va} < NW'(W))
                                && ({1'b0, r_vb} < NW'(W));
    assign o_stat.no_vertices = (r_num == '0);
    assign o_stat.prune       = prune;
    assign o_stat.last_entry  = (r_depth == CW'(1));
    assign o_stat.push_ok     = (child != '0) && push_room;
    assign o_stat.out_busy    = r_out_vld && !i_out_ready;

    // configuration and request fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= NW'(64);
        end else if (i_cfg_valid) begin
            r_num <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_va <= i_vertex_a;
            r_vb <= i_vertex_b;
        end
    end

    // adjacency read address
    always_comb begin
        adj_rd_addr = va_idx;
        if (i_cmd.edge_wr_a) begin
            adj_rd_addr = vb_idx;
        end else if (i_cmd.srch_eval) begin
            adj_rd_addr = low_idx;
        end
    end

    // adjacency memory with registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.edge_wr_a) begin
            m_adj[va_idx] <= row | (W'(1) << vb_idx);
        end else if (i_cmd.edge_wr_b) begin
            m_adj[vb_idx] <= row | (W'(1) << va_idx);
        end
        r_adj_q <= m_adj[adj_rd_addr];
    end

    // row valid bits, cleared by reset and by a clear request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_adj_qv  <= 1'b0;
        end else begin
            r_adj_qv <= r_row_vld[adj_rd_addr];
            if (i_cmd.graph_clr) begin
                r_row_vld <= '0;
            end else if (i_cmd.edge_wr_a) begin
                r_row_vld[va_idx] <= 1'b1;
            end else if (i_cmd.edge_wr_b) begin
                r_row_vld[vb_idx] <= 1'b1;
            end
        end
    end

    // stack memory below the top entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_adj && (child != '0) && push_room) begin
            m_stk[depth_m1[AW-1:0]] <= {r_clq, r_cand};
        end
        r_stk_q <= m_stk[depth_m2[AW-1:0]];
    end

    // top of stack, depth and best clique
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clq       <= '0;
            r_cand      <= '0;
            r_depth     <= '0;
            r_best_mask <= '0;
            r_best_size <= '0;
        end else if (i_cmd.srch_init) begin
            r_clq       <= '0;
            r_cand      <= all_mask;
            r_depth     <= CW'(1);
            r_best_mask <= '0;
            r_best_size <= '0;
        end else if (i_cmd.srch_count) begin
            r_cs <= f_pop(r_clq);
            r_cc <= f_pop(r_cand);
        end else if (i_cmd.srch_eval) begin
            if (cs_gt) begin
                r_best_mask <= r_clq;
                r_best_size <= r_cs;
            end
            if (prune) begin
                r_depth <= depth_m1;
            end else begin
                r_bit  <= W'(1) << low_idx;
                r_cand <= r_cand & ~(W'(1) << low_idx);
                r_cc   <= r_cc - CW'(1);
            end
        end else if (i_cmd.srch_adj) begin
            if (child == '0) begin
                if (leaf_better) begin
                    r_best_mask <= r_clq | r_bit;
                    r_best_size <= r_cs + CW'(1);
                end
            end else if (push_room) begin
                r_clq   <= r_clq | r_bit;
                r_cand  <= child;
                r_depth <= r_depth + CW'(1);
            end
        end else if (i_cmd.srch_pop) begin
            r_clq  <= r_stk_q[2*W-1:W];
            r_cand <= r_stk_q[W-1:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_mask <= r_best_mask;
            r_out_size <= r_best_size;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_clique_mask = MW'(r_out_mask);
    assign o_clique_size = ZW'(r_out_size);

    `MCS_ASSERT_ALWAYS(a_depth_bound, r_depth <= CW'(W), "stack depth above vertex count")
    `MCS_ASSERT_ALWAYS(a_disjoint, (r_clq & r_cand) == '0, "candidate already in clique")
    `MCS_ASSERT_NEXT(a_walk_ends, i_cmd.srch_eval && prune && (r_depth == CW'(1)), r_depth == '0, "last pop left entries")

endmodule

### verif/clique_result_checker.sv
// ----------------------------------------------------------------------------
// clique result checker
// Watches the request, result and config channels of the maximum clique
// search core. Keeps its own adjacency matrix and vertex count, computes the
// expected clique for every accepted search and compares each result with it.
// ----------------------------------------------------------------------------
module clique_result_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_req_tvalid,
    input  logic                            i_req_tready,
    input  logic [mcs_pkg::IN_DATA_W-1:0]   i_req_tdata,   // vertex_a, vertex_b, zero pad
    input  logic [mcs_pkg::REQ_W-1:0]       i_req_tuser,   // req_type
    // result channel
    input  logic                            i_res_tvalid,
    input  logic                            i_res_tready,
    input  logic [mcs_pkg::OUT_DATA_W-1:0]  i_res_tdata,   // clique_mask, clique_size, zero pad
    // vertex count write channel
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [mcs_pkg::NUM_W-1:0]       i_cfg_data,
    output int                              o_err_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MW = mcs_pkg::MASK_W;
    localparam int ZW = mcs_pkg::SIZE_W;
    localparam int VW = mcs_pkg::VERTEX_W;
    localparam int NW = mcs_pkg::NUM_W;

    typedef struct packed {
        logic [MW-1:0] mask;
        logic [ZW-1:0] size;
    } t_clique;

    logic [MW-1:0] adjacency [64];
    logic [NW-1:0] vertex_count;
    t_clique       expected_cliques [$];
    int            mismatch_count = 0;
    int            waiting_count  = 0;

    assign o_err_count = mismatch_count;
    assign o_pending   = waiting_count;

    // one line per failure, and count it
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns clique check, %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // depth-first branch and bound, lowest candidate first, explicit stack
    function automatic t_clique find_max_clique();
        logic [63:0] clq_stack [64];
        logic [63:0] cand_stack [64];
        t_clique     best;
        int          depth;
        int          top;
        int          n;
        int          v;
        int          cs;
        logic [63:0] full_set;
        logic [63:0] clq;
        logic [63:0] cand;
        logic [63:0] vbit;
        logic [63:0] child;
        n        = (vertex_count > NW'(64)) ? 64 : int'(vertex_count);
        full_set = (n == 64) ? '1 : ((64'd1 << n) - 64'd1);
        best     = '0;
        depth    = 0;
        if (full_set != 64'd0) begin
            clq_stack[0]  = 64'd0;
            cand_stack[0] = full_set;
            depth         = 1;
        end
        while (depth > 0) begin
            top  = depth - 1;
            clq  = clq_stack[top];
            cand = cand_stack[top];
            cs   = $countones(clq);
            if (cs > int'(best.size)) begin
                best.size = ZW'(cs);
                best.mask = clq;
            end
            // exhausted or cannot beat the best so far
            if (cand == 64'd0 || cs + $countones(cand) <= int'(best.size)) begin
                depth--;
            end else begin
                v = 0;
                while (v < 63 && !cand[v])
                    v++;
                vbit            = 64'd1 << v;
                cand            = cand & ~vbit;
                cand_stack[top] = cand;
                child           = cand & adjacency[v];
                // leaf child is scored right away, never pushed
                if (child == 64'd0) begin
                    if (cs + 1 > int'(best.size)) begin
                        best.size = ZW'(cs + 1);
                        best.mask = clq | vbit;
                    end
                end else if (depth < 64) begin
                    clq_stack[depth]  = clq | vbit;
                    cand_stack[depth] = child;
                    depth++;
                end
            end
        end
        return best;
    endfunction

    always @(posedge i_clk) begin : watch
        t_clique       got;
        t_clique       want;
        logic [VW-1:0] va;
        logic [VW-1:0] vb;
        if (!i_rst_n) begin
            for (int i = 0; i < 64; i++)
                adjacency[i] = '0;
            vertex_count = NW'(64);
            expected_cliques.delete();
        end else begin
            // results first, so a search taken in this cycle is never matched
            if (i_res_tvalid && i_res_tready) begin
                got.mask = i_res_tdata[MW-1:0];
                got.size = i_res_tdata[MW +: ZW];
                if (expected_cliques.size() == 0) begin
                    report_mismatch("result with no search waiting", got.mask, 64'd0);
                end else begin
                    want = expected_cliques[0];
                    expected_cliques.delete(0);
                    if (got.mask !== want.mask)
                        report_mismatch("clique_mask", got.mask, want.mask);
                    if (got.size !== want.size)
                        report_mismatch("clique_size", 64'(got.size), 64'(want.size));
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                vertex_count = i_cfg_data;
            // request decode
            if (i_req_tvalid && i_req_tready) begin
                va = i_req_tdata[VW-1:0];
                vb = i_req_tdata[VW +: VW];
                case (i_req_tuser)
                    mcs_pkg::REQ_ADD_EDGE: begin
                        // self loops are dropped
                        if (va != vb) begin
                            adjacency[va][vb] = 1'b1;
                            adjacency[vb][va] = 1'b1;
                        end
                    end
                    mcs_pkg::REQ_SEARCH: begin
                        expected_cliques.insert(expected_cliques.size(), find_max_clique());
                    end
                    mcs_pkg::REQ_CLEAR: begin
                        for (int i = 0; i < 64; i++)
                            adjacency[i] = '0;
                    end
                    default: begin
                        // unused request code, nothing happens
                    end
                endcase
            end
        end
        waiting_count = expected_cliques.size();
    end

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// maximum clique search testbench
// Drives edge, search and clear requests into the core with random gaps and
// random result back-pressure, over several vertex counts and graph shapes
// (dense small graphs, sparse wide graphs, planted cliques). The checker
// beside the core predicts every search result and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RW = mcs_pkg::REQ_W;
    localparam int VW = mcs_pkg::VERTEX_W;
    localparam int NW = mcs_pkg::NUM_W;
    localparam int DW = mcs_pkg::IN_DATA_W;
    localparam int OW = mcs_pkg::OUT_DATA_W;

    localparam logic [RW-1:0] REQ_UNUSED = 2'd3;
    localparam int     RANDOM_REQUESTS = 850;
    localparam int     MAX_WAIT        = 12;
    localparam int     EDGE_SETTLE     = 8;
    localparam int     DRAIN_CYCLES    = 50;
    localparam longint CYCLE_LIMIT     = 5_000_000;

    typedef enum int {
        FILL_DENSE,
        FILL_SPARSE,
        FILL_PLANTED
    } t_fill;

    logic           i_clk;
    logic           i_rst_n;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [DW-1:0]  s_axis_tdata;   // vertex_a, vertex_b, zero pad
    logic [RW-1:0]  s_axis_tuser;   // req_type
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [OW-1:0]  m_axis_tdata;   // clique_mask, clique_size, zero pad
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [NW-1:0]  i_cfg_data;

    int     err_count;
    int     pending;
    int     send_quiet = 0;
    int     recv_quiet = 0;
    longint cycle_cnt  = 0;

    maximum_clique_search_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    clique_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_tvalid   (s_axis_tvalid),
        .i_req_tready   (s_axis_tready),
        .i_req_tdata    (s_axis_tdata),
        .i_req_tuser    (s_axis_tuser),
        .i_res_tvalid   (m_axis_tvalid),
        .i_res_tready   (m_axis_tready),
        .i_res_tdata    (m_axis_tdata),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_err_count    (err_count),
        .o_pending      (pending)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // wait length per request, with occasional runs of back-to-back traffic
    function automatic int draw_wait(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet_left = $urandom_range(5, 40);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // random vertex from a nonempty set
    function automatic logic [VW-1:0] pick_member(input logic [63:0] members);
        logic [VW-1:0] v;
        v = VW'($urandom_range(0, 63));
        while (!members[v])
            v = v + 1'b1;
        return v;
    endfunction

    // one request, entered and left at a falling edge
    task automatic send_request(input logic [RW-1:0] kind,
                                input logic [VW-1:0] va,
                                input logic [VW-1:0] vb);
        int gap;
        gap = draw_wait(send_quiet);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = {{(DW - 2 * VW){1'b0}}, vb, va};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // hold requests until every search has answered and edge writes have retired
    task automatic settle_idle();
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (EDGE_SETTLE) @(negedge i_clk);
    endtask

    task automatic write_vertex_count(input logic [NW-1:0] count);
        settle_idle();
        i_cfg_valid = 1'b1;
        i_cfg_data  = count;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // empty the graph and pick the shape of the next one
    task automatic start_graph(input t_fill fill, input int span,
                               output int cap, output logic [63:0] members);
        int k;
        send_request(mcs_pkg::REQ_CLEAR, VW'($urandom), VW'($urandom));
        members = '0;
        case (fill)
            FILL_DENSE:  cap = $urandom_range(2, span * (span - 1) / 4 + 2);
            FILL_SPARSE: cap = $urandom_range(10, 120);
            default: begin
                k = $urandom_range(3, 20);
                repeat (k) members[$urandom_range(0, 63)] = 1'b1;
                cap = k * k;
            end
        endcase
    endtask

    // result side: random hold-off, sometimes ready before the result shows
    initial begin : result_sink
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            stall = draw_wait(recv_quiet);
            if (stall == 0) begin
                m_axis_tready = 1'b1;
            end else begin
                m_axis_tready = 1'b0;
                do @(posedge i_clk); while (!m_axis_tvalid);
                repeat (stall) @(negedge i_clk);
                m_axis_tready = 1'b1;
            end
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    // request stimulus and verdict
    initial begin : stimulus
        int            sent;
        int            phase;
        int            phase_len;
        int            cap;
        int            edges;
        int            span;
        int            eff;
        int            r;
        t_fill         fill;
        logic [NW-1:0] count;
        logic [63:0]   members;
        logic [VW-1:0] va;
        logic [VW-1:0] vb;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty graph at the reset vertex count
        send_request(mcs_pkg::REQ_SEARCH, 6'd0, 6'd0);
        // edge between the outermost vertices, its mirror, a self loop, an unused code
        send_request(mcs_pkg::REQ_ADD_EDGE, 6'd0, 6'd63);
        send_request(mcs_pkg::REQ_ADD_EDGE, 6'd63, 6'd0);
        send_request(mcs_pkg::REQ_ADD_EDGE, 6'd5, 6'd5);
        send_request(REQ_UNUSED, 6'd63, 6'd63);
        send_request(mcs_pkg::REQ_SEARCH, 6'd63, 6'd0);
        // triangle on vertices 0, 62 and 63
        send_request(mcs_pkg::REQ_ADD_EDGE, 6'd62, 6'd63);
        send_request(mcs_pkg::REQ_ADD_EDGE, 6'd0, 6'd62);
        send_request(mcs_pkg::REQ_SEARCH, 6'd0, 6'd0);
        send_request(mcs_pkg::REQ_CLEAR, 6'd63, 6'd63);
        send_request(mcs_pkg::REQ_SEARCH, 6'd0, 6'd0);
        // no vertices at all
        write_vertex_count(7'd0);
        send_request(mcs_pkg::REQ_ADD_EDGE, 6'd1, 6'd2);
        send_request(mcs_pkg::REQ_SEARCH, 6'd0, 6'd0);
        write_vertex_count(7'd1);
        send_request(mcs_pkg::REQ_SEARCH, 6'd0, 6'd0);
        // stored edge outside the vertex range is not used
        write_vertex_count(7'd2);
        send_request(mcs_pkg::REQ_ADD_EDGE, 6'd0, 6'd63);
        send_request(mcs_pkg::REQ_SEARCH, 6'd0, 6'd0);
        send_request(mcs_pkg::REQ_ADD_EDGE, 6'd1, 6'd0);
        send_request(mcs_pkg::REQ_SEARCH, 6'd0, 6'd0);
        // oversized vertex count saturates
        write_vertex_count(7'd127);
        send_request(mcs_pkg::REQ_SEARCH, 6'd0, 6'd0);
        send_request(mcs_pkg::REQ_CLEAR, 6'd0, 6'd0);

        // random phases, each at one vertex count and graph shape
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_REQUESTS) begin
            case (phase)
                0:       count = 7'd64;
                1:       count = 7'd0;
                2:       count = 7'd127;
                3:       count = 7'd1;
                4:       count = 7'd2;
                default: begin
                    case ($urandom_range(0, 4))
                        0:       count = NW'($urandom_range(2, 16));
                        1:       count = NW'($urandom_range(17, 40));
                        2:       count = 7'd64;
                        3:       count = NW'($urandom_range(65, 127));
                        default: count = NW'($urandom_range(0, 24));
                    endcase
                end
            endcase
            write_vertex_count(count);
            eff  = (count > 7'd64) ? 64 : int'(count);
            span = (eff < 2) ? 2 : ((eff > 24) ? 24 : eff);
            if (eff <= 24 && $urandom_range(0, 3) != 0)
                fill = FILL_DENSE;
            else
                fill = t_fill'($urandom_range(0, 2));
            start_graph(fill, span, cap, members);
            edges = 0;
            sent++;
            phase_len = $urandom_range(30, 110);
            repeat (phase_len) begin
                r = $urandom_range(0, 99);
                va = VW'($urandom);
                vb = VW'($urandom);
                if (edges >= cap || (r >= 14 && r < 16)) begin
                    // graph is full enough, or at random, start over
                    start_graph(fill, span, cap, members);
                    edges = 0;
                    sent++;
                end else if (r < 12) begin
                    send_request(mcs_pkg::REQ_SEARCH, va, vb);
                    sent++;
                end else if (r < 14) begin
                    // ignored by the core, not counted
                    send_request(REQ_UNUSED, va, vb);
                end else if (r < 18) begin
                    send_request(mcs_pkg::REQ_ADD_EDGE, va, va);
                    sent++;
                end else begin
                    case (fill)
                        FILL_DENSE: begin
                            va = VW'($urandom_range(0, span - 1));
                            vb = VW'($urandom_range(0, span - 1));
                        end
                        FILL_PLANTED: begin
                            if (members != 64'd0 && $urandom_range(0, 99) < 85) begin
                                va = pick_member(members);
                                vb = pick_member(members);
                            end
                        end
                        default: begin
                        end
                    endcase
                    send_request(mcs_pkg::REQ_ADD_EDGE, va, vb);
                    edges++;
                    sent++;
                end
            end
            send_request(mcs_pkg::REQ_SEARCH, VW'($urandom), VW'($urandom));
            sent++;
            phase++;
        end

        // drain
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (err_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
